// File: sv/mbss_pkg.sv
// ----------------------------------------------------------------------------
// mbss_pkg
// Shared types, constants and the boot image of the multiplexed bus SRAM slave.
// ----------------------------------------------------------------------------
package mbss_pkg;

  localparam int RAM_BYTES_DEF = 1024;
  localparam int IMAGE_LEN     = 32;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SUM,
    ST_WRAP,
    ST_MEM,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_WRITE,
    KIND_READ
  } acc_kind_t;

  typedef struct packed {
    logic       en;
    logic       we;
    logic [7:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic load_sum;
    logic load_idx;
  } idx_ctl_t;

  function automatic logic [7:0] boot_byte(input logic [4:0] i);
    logic [7:0] b;
    case (i)
      5'd0:    b = 8'hb7;
      5'd1:    b = 8'h01;
      5'd2:    b = 8'h00;
      5'd3:    b = 8'he0;
      5'd4:    b = 8'hb7;
      5'd5:    b = 8'h02;
      5'd6:    b = 8'h00;
      5'd7:    b = 8'h20;
      5'd8:    b = 8'h13;
      5'd9:    b = 8'h02;
      5'd10:   b = 8'h00;
      5'd11:   b = 8'h02;
      5'd12:   b = 8'h23;
      5'd13:   b = 8'h80;
      5'd14:   b = 8'h41;
      5'd15:   b = 8'h00;
      5'd16:   b = 8'h23;
      5'd17:   b = 8'h90;
      5'd18:   b = 8'h42;
      5'd19:   b = 8'h04;
      5'd20:   b = 8'h93;
      5'd21:   b = 8'h82;
      5'd22:   b = 8'h22;
      5'd23:   b = 8'h00;
      5'd24:   b = 8'h13;
      5'd25:   b = 8'h02;
      5'd26:   b = 8'h12;
      5'd27:   b = 8'h00;
      5'd28:   b = 8'h6f;
      5'd29:   b = 8'hf0;
      5'd30:   b = 8'h1f;
      5'd31:   b = 8'hff;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: sv/mbss_ram.sv
// ----------------------------------------------------------------------------
// mbss_ram
// Single-port byte memory, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module mbss_ram #(
  parameter int RAM_BYTES = mbss_pkg::RAM_BYTES_DEF,
  localparam int AW = $clog2(RAM_BYTES)
) (
  input  logic               clk,
  input  mbss_pkg::mem_req_t req,
  input  logic [AW-1:0]      addr,
  output logic [7:0]         rdata
);
  import mbss_pkg::*;

  logic [7:0] mem [RAM_BYTES];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        mem[addr] <= req.wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/mbss_index.sv
// ----------------------------------------------------------------------------
// mbss_index
// Reduces the byte address {high, low, lanes} modulo the memory size in two
// registered steps using per-byte residue tables.
// ----------------------------------------------------------------------------
module mbss_index #(
  parameter int RAM_BYTES = mbss_pkg::RAM_BYTES_DEF,
  localparam int AW = $clog2(RAM_BYTES)
) (
  input  logic               clk,
  input  mbss_pkg::idx_ctl_t ctl,
  input  logic [7:0]         addr_hi,
  input  logic [7:0]         addr_lo,
  input  logic [1:0]         addr_ln,
  output logic [AW-1:0]      idx
);
  import mbss_pkg::*;

  logic [AW-1:0] hi_tab [256];
  logic [AW-1:0] lo_tab [256];

  for (genvar g = 0; g < 256; g++) begin : g_tab
    localparam int HiMod = (g * 1024) % RAM_BYTES;
    localparam int LoMod = (g * 4) % RAM_BYTES;
    assign hi_tab[g] = AW'(HiMod);
    assign lo_tab[g] = AW'(LoMod);
  end

  localparam logic [AW:0] MOD = (AW + 1)'(RAM_BYTES);

  logic [AW:0]   sum1, sum2, red1, red2;
  logic [AW-1:0] s1_r, idx_r;
  logic [1:0]    ln_r;

  assign sum1 = {1'b0, hi_tab[addr_hi]} + {1'b0, lo_tab[addr_lo]};
  assign red1 = (sum1 >= MOD) ? sum1 - MOD : sum1;
  assign sum2 = {1'b0, s1_r} + (AW + 1)'(ln_r);
  assign red2 = (sum2 >= MOD) ? sum2 - MOD : sum2;

  always_ff @(posedge clk) begin
    if (ctl.load_sum) begin
      s1_r <= red1[AW-1:0];
      ln_r <= addr_ln;
    end
    if (ctl.load_idx) begin
      idx_r <= red2[AW-1:0];
    end
  end

  assign idx = idx_r;

endmodule

// File: sv/multiplexed_bus_sram_slave.sv
// ----------------------------------------------------------------------------
// multiplexed_bus_sram_slave
// Byte-wide memory slave for a multiplexed address/data bus, one pin sample
// per input transfer, one result transfer per sample.
// ----------------------------------------------------------------------------
// After reset the memory is loaded with the 32-byte boot image and zeros in
// a sweep over all RAM_BYTES addresses, one byte per cycle; in_tready stays
// low until it ends. Then one sample is handled at a time: a sample with no
// access passes accept and result; a read or write passes accept, the SUM
// and WRAP reduction steps, the memory access and result, as set by the
// index reduction and the single memory port. The result waits for a free
// output register, where it stays while the next sample is taken.
// ----------------------------------------------------------------------------
module multiplexed_bus_sram_slave #(
  parameter int RAM_BYTES = mbss_pkg::RAM_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] bus_byte, [8] latch_low, [9] latch_high, [10] lane_bit0,
  // [11] lane_bit1, [12] write_n, [13] read_n, [15:14] zero
  input  logic [15:0] in_tdata,
  // [0] phase
  input  logic [0:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] read_valid, [8:1] read_data, [9] write_valid,
  // [19:10] access_address, [23:20] zero
  output logic [23:0] out_tdata
);
  import mbss_pkg::*;

  localparam int AW = $clog2(RAM_BYTES);
  localparam int XW = (AW > 10) ? AW : 10;

  state_t        state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [7:0]    addr_hi_r, addr_hi_nxt;
  logic [7:0]    addr_lo_r, addr_lo_nxt;
  logic [1:0]    addr_ln_r, addr_ln_nxt;
  acc_kind_t     kind_r, kind_nxt;
  logic [7:0]    wdata_r, wdata_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [23:0]   out_data_r, out_data_nxt;

  mem_req_t      mem_req;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_rdata;
  idx_ctl_t      idx_ctl;
  logic [AW-1:0] idx;
  logic [XW-1:0] clr_x, idx_x;
  logic [7:0]    clr_byte;
  logic          out_free;
  logic          is_read, is_write;

  mbss_index #(.RAM_BYTES(RAM_BYTES)) u_index (
    .clk     (clk),
    .ctl     (idx_ctl),
    .addr_hi (addr_hi_r),
    .addr_lo (addr_lo_r),
    .addr_ln (addr_ln_r),
    .idx     (idx)
  );

  mbss_ram #(.RAM_BYTES(RAM_BYTES)) u_ram (
    .clk   (clk),
    .req   (mem_req),
    .addr  (mem_addr),
    .rdata (mem_rdata)
  );

  assign clr_x    = XW'(clr_cnt_r);
  assign clr_byte = (clr_x < XW'(IMAGE_LEN)) ? boot_byte(clr_x[4:0]) : 8'h00;
  assign idx_x    = XW'(idx);
  assign out_free = !out_valid_r || out_tready;
  assign is_read  = (kind_r == KIND_READ);
  assign is_write = (kind_r == KIND_WRITE);

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    addr_hi_nxt   = addr_hi_r;
    addr_lo_nxt   = addr_lo_r;
    addr_ln_nxt   = addr_ln_r;
    kind_nxt      = kind_r;
    wdata_nxt     = wdata_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mem_req       = '0;
    mem_addr      = idx;
    idx_ctl       = '0;
    in_tready     = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        mem_req.en    = 1'b1;
        mem_req.we    = 1'b1;
        mem_req.wdata = clr_byte;
        mem_addr      = clr_cnt_r;
        if (clr_cnt_r == AW'(RAM_BYTES - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          kind_nxt  = KIND_NONE;
          wdata_nxt = in_tdata[7:0];
          if (!in_tuser[0]) begin
            if (in_tdata[8]) begin
              addr_hi_nxt = 8'h00;
              addr_lo_nxt = in_tdata[7:0];
              addr_ln_nxt = 2'b00;
            end
            if (in_tdata[9]) begin
              addr_hi_nxt = addr_hi_nxt | in_tdata[7:0];
            end
            if (!in_tdata[12]) begin
              addr_ln_nxt = in_tdata[11:10];
              kind_nxt    = KIND_WRITE;
            end
          end else if (!in_tdata[13]) begin
            addr_ln_nxt = in_tdata[11:10];
            kind_nxt    = KIND_READ;
          end
          state_nxt = (kind_nxt == KIND_NONE) ? ST_OUT : ST_SUM;
        end
      end
      ST_SUM: begin
        idx_ctl.load_sum = 1'b1;
        state_nxt        = ST_WRAP;
      end
      ST_WRAP: begin
        idx_ctl.load_idx = 1'b1;
        state_nxt        = ST_MEM;
      end
      ST_MEM: begin
        mem_req.en    = 1'b1;
        mem_req.we    = is_write;
        mem_req.wdata = wdata_r;
        state_nxt     = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {4'b0000,
                           (is_read || is_write) ? idx_x[9:0] : 10'd0,
                           is_write,
                           is_read ? mem_rdata : 8'h00,
                           is_read};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      addr_hi_r   <= '0;
      addr_lo_r   <= '0;
      addr_ln_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      addr_hi_r   <= addr_hi_nxt;
      addr_lo_r   <= addr_lo_nxt;
      addr_ln_r   <= addr_ln_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    wdata_r    <= wdata_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
